[sv/adp_pkg.sv]
// Package for the archive directory parser: parser state and result types,
// record layout positions and the name character cleanup function.
// Depends on nothing; used by adp_step and archive_directory_parser_core.
package adp_pkg;

	// Most live records that may ever be reported.
	localparam logic [6:0] MAX_LIVE = 7'd64;
	localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;

	// Byte positions inside one 32-byte directory record.
	localparam logic [4:0] POS_STATUS    = 5'd0;
	localparam logic [4:0] POS_NAME_LAST = 5'd8;
	localparam logic [4:0] POS_EXT_LAST  = 5'd11;
	localparam logic [4:0] POS_START_LO  = 5'd12;
	localparam logic [4:0] POS_START_HI  = 5'd13;
	localparam logic [4:0] POS_SIZE_LO   = 5'd14;
	localparam logic [4:0] POS_SIZE_HI   = 5'd15;
	localparam logic [4:0] POS_REC_LAST  = 5'd31;

	// Character codes used by the cleanup.
	localparam logic [6:0] CHR_SPACE = 7'h20;
	localparam logic [6:0] CHR_LC_A  = 7'h61;
	localparam logic [6:0] CHR_LC_Z  = 7'h7a;
	localparam logic [6:0] CHR_SEMI  = 7'h3b;
	localparam logic [6:0] CHR_STAR  = 7'h2a;
	localparam logic [6:0] CHR_DOT   = 7'h2e;
	localparam logic [6:0] CASE_DIFF = 7'h20;

	// Parser state carried from one byte to the next.
	typedef struct packed {
		logic        active;
		logic [4:0]  byte_in_record;
		logic [17:0] record_index;
		logic [17:0] record_total;
		logic [6:0]  live_seen;
		logic        skip_record;
		logic [63:0] name_chars;
		logic [3:0]  name_length;
		logic [23:0] ext_chars;
		logic [1:0]  ext_length;
		logic [7:0]  low_byte;
		logic [15:0] start_index;
	} adp_state_t;

	// One result item.
	typedef struct packed {
		logic        is_entry;
		logic        last;
		logic [63:0] entry_name;
		logic [23:0] entry_ext;
		logic [22:0] offset_bytes;
		logic [15:0] size_sectors;
		logic [6:0]  live_count;
	} adp_result_t;

	// Cleans one name or extension byte. A result of zero means the
	// character is dropped; a kept character is never zero.
	function automatic logic [7:0] clean_char(input logic [7:0] b);
		logic [6:0] c;
		c = b[6:0];
		if (c == CHR_SPACE) begin
			return 8'h00;
		end
		if (c >= CHR_LC_A && c <= CHR_LC_Z) begin
			c = c - CASE_DIFF;
		end
		if (c == CHR_SEMI || c == CHR_STAR || c < CHR_SPACE) begin
			c = CHR_DOT;
		end
		return {1'b0, c};
	endfunction

endpackage

[sv/adp_step.sv]
// Next-state and result logic of the archive directory parser for one byte.
// Purely combinational; uses the types and cleanup function of adp_pkg.
module adp_step (
	input  adp_pkg::adp_state_t  st,
	input  logic [7:0]           data_byte,
	input  logic                 start_req,
	input  logic [6:0]           max_entries,
	output adp_pkg::adp_state_t  nxt,
	output logic                 emit,
	output adp_pkg::adp_result_t res
);

	adp_pkg::adp_state_t cur;
	logic [7:0]  c;
	logic [17:0] total;
	logic [6:0]  limit;
	logic [6:0]  live_inc;
	logic        final_rec;
	logic        done;
	logic        stop;
	logic [2:0]  name_slot;
	logic [1:0]  ext_slot;
	logic [4:0]  p;

	// Shared terms: cleaned character, limit in force, directory length, name and extension slots.
	always_comb begin
		c         = adp_pkg::clean_char(data_byte);
		limit     = (max_entries >= adp_pkg::MAX_LIVE) ? adp_pkg::MAX_LIVE : max_entries;
		total     = {data_byte, st.low_byte, 2'b00};
		name_slot = 3'(3'd7 - st.name_length[2:0]);
		ext_slot  = 2'(2'd2 - st.ext_length);
	end

	// Byte handling for the current record position.
	always_comb begin
		cur = st;
		if (start_req) begin
			cur = '0;
			cur.active = 1'b1;
		end
		p         = cur.byte_in_record;
		live_inc  = cur.live_seen + 7'd1;
		final_rec = ({1'b0, cur.record_index} + 19'd1) >= {1'b0, cur.record_total};
		done      = final_rec || (live_inc >= limit);
		nxt       = cur;
		emit      = 1'b0;
		stop      = 1'b0;
		res       = '0;
		res.last       = 1'b1;
		res.live_count = cur.live_seen;

		if (cur.active) begin
			if (cur.record_index == '0) begin
				// The first record only carries the directory length.
				if (p == adp_pkg::POS_SIZE_LO) begin
					nxt.low_byte = data_byte;
				end else if (p == adp_pkg::POS_SIZE_HI) begin
					nxt.record_total = total;
					if (total <= 18'd1 || limit == '0) begin
						emit = 1'b1;
						stop = 1'b1;
					end
				end
			end else begin
				if (p == adp_pkg::POS_STATUS) begin
					nxt.skip_record = (data_byte != 8'h00);
					nxt.name_chars  = '0;
					nxt.name_length = '0;
					nxt.ext_chars   = '0;
					nxt.ext_length  = '0;
				end else if (p <= adp_pkg::POS_NAME_LAST) begin
					if (c != 8'h00 && cur.name_length < 4'd8) begin
						nxt.name_chars[{name_slot, 3'b000} +: 8] = c;
						nxt.name_length = cur.name_length + 4'd1;
					end
				end else if (p <= adp_pkg::POS_EXT_LAST) begin
					if (c != 8'h00 && cur.ext_length < 2'd3) begin
						nxt.ext_chars[{ext_slot, 3'b000} +: 8] = c;
						nxt.ext_length = cur.ext_length + 2'd1;
					end
				end else if (p == adp_pkg::POS_START_LO || p == adp_pkg::POS_SIZE_LO) begin
					nxt.low_byte = data_byte;
				end else if (p == adp_pkg::POS_START_HI) begin
					nxt.start_index = {data_byte, cur.low_byte};
				end else if (p == adp_pkg::POS_SIZE_HI) begin
					if (cur.skip_record) begin
						// A dead final record still closes the directory.
						if (final_rec) begin
							emit = 1'b1;
							stop = 1'b1;
						end
					end else begin
						nxt.live_seen    = live_inc;
						emit             = 1'b1;
						stop             = done;
						res.is_entry     = 1'b1;
						res.last         = done;
						res.entry_name   = cur.name_chars;
						res.entry_ext    = cur.ext_chars;
						res.offset_bytes = {cur.start_index, 7'b0000000};
						res.size_sectors = {data_byte, cur.low_byte};
						res.live_count   = live_inc;
					end
				end
			end

			// Finish the directory, or move on to the next byte.
			if (stop) begin
				nxt.active = 1'b0;
			end else if (p == adp_pkg::POS_REC_LAST) begin
				nxt.byte_in_record = '0;
				nxt.record_index   = cur.record_index + 18'd1;
			end else begin
				nxt.byte_in_record = p + 5'd1;
			end
		end
	end

endmodule

[sv/archive_directory_parser_core.sv]
// Top level of the archive directory parser: input stage, parser state,
// limit register and result register. Depends on adp_pkg and adp_step.
//
// Usage: archive bytes arrive on the input channel (in_valid, in_stall,
// data_byte, start_req), one item per byte; start_req marks archive byte 0
// and restarts the parser at any time. Each 32-byte directory record after
// the first yields at most one result item on the output channel (out_valid,
// out_stall and the result fields): a live record at its byte 15, or an
// end-only marker when the directory closes without a live record.
// Bytes that arrive while the parser is idle are taken and dropped.
// The limit on live records is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which it does not enforce.
// Throughput: one byte per cycle while in_stall is low; the whole per-byte
// step sits between the input stage register and the result register.
// When the receiver stalls, the result register holds its item; bytes that
// produce no result keep flowing, and a byte that would produce a further
// result waits in the input stage, which raises in_stall until it is taken.
// Reset clears the parser to idle, empties both registers and sets the limit
// to 64.
module archive_directory_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [6:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_entry,
	output logic        last,
	output logic [63:0] entry_name,
	output logic [23:0] entry_ext,
	output logic [22:0] offset_bytes,
	output logic [15:0] size_sectors,
	output logic [6:0]  live_count
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 start_s1;
	logic [6:0]           max_entries_q;
	adp_pkg::adp_state_t  state_q;
	adp_pkg::adp_state_t  state_nxt;
	logic                 emit;
	adp_pkg::adp_result_t res;
	adp_pkg::adp_result_t res_q;
	logic                 out_valid_q;
	logic                 fire;

	// Per-byte parser step.
	adp_step u_step (
		.st          (state_q),
		.data_byte   (data_s1),
		.start_req   (start_s1),
		.max_entries (max_entries_q),
		.nxt         (state_nxt),
		.emit        (emit),
		.res         (res)
	);

	// The staged item moves on unless its result would meet a full, stalled
	// result register.
	assign fire     = valid_s1 && !(emit && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !fire;

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= adp_pkg::MAX_ENTRIES_RESET;
		end else if (cfg_wr_en) begin
			max_entries_q <= cfg_wr_data;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1  <= data_byte;
			start_s1 <= start_req;
		end
	end

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_entry     = res_q.is_entry;
	assign last         = res_q.last;
	assign entry_name   = res_q.entry_name;
	assign entry_ext    = res_q.entry_ext;
	assign offset_bytes = res_q.offset_bytes;
	assign size_sectors = res_q.size_sectors;
	assign live_count   = res_q.live_count;

endmodule
